// ----- hw/rtl/gtlc_pkg.sv -----
// Shared types, codes and constants of the generation-tagged lookup cache.
`default_nettype none
package gtlc_pkg;

	localparam int ENTRIES_DEF = 4096;
	localparam int Q_DEPTH     = 2;

	localparam logic [2:0] FN_LOOKUP = 3'd0;
	localparam logic [2:0] FN_FILL   = 3'd1;
	localparam logic [2:0] FN_INVAL  = 3'd2;
	localparam logic [2:0] FN_GC     = 3'd3;
	localparam logic [2:0] FN_CLEAR  = 3'd4;

	localparam logic [1:0] ST_HIT  = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_SKIP = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [3:0]  TYPE_TABLE  = 4'd5;
	localparam logic [3:0]  TYPE_STRING = 4'd4;
	localparam logic [3:0]  VTYPE_MIN   = 4'd1;
	localparam logic [3:0]  VTYPE_MAX   = 4'd4;
	localparam logic [31:0] ADDR_MIN    = 32'h0001_0000;
	localparam logic [31:0] ADDR_MAX    = 32'hFFE0_0000;
	localparam logic [31:0] GEN_RESET   = 32'd1;

	typedef enum logic [2:0] {
		OP_LOOKUP,
		OP_FILL,
		OP_INVAL,
		OP_GC,
		OP_CLEAR,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_SWEEP
	} bk_state_t;

	typedef struct packed {
		op_t         op;
		logic        go;
		logic [31:0] owner;
		logic [31:0] t_addr;
		logic [31:0] k_addr;
		logic [31:0] hash;
		logic [63:0] vbits;
		logic [3:0]  vtype;
		logic [31:0] vtaint;
	} q_item_t;

	typedef struct packed {
		logic [63:0] tag;
		logic [63:0] value;
		logic [3:0]  vtype;
		logic [31:0] taint;
		logic [31:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ----- hw/rtl/gtlc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gtlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/gtlc_front.sv -----
// Front end: accepts request beats, decodes and qualifies them, hashes the slot.
`default_nettype none
module gtlc_front (
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         func,
	input  wire logic               bypass,
	input  wire logic [31:0]        owner_id,
	input  wire logic [3:0]         table_type,
	input  wire logic [3:0]         key_type,
	input  wire logic [31:0]        table_addr,
	input  wire logic [31:0]        key_addr,
	input  wire logic [63:0]        value_bits,
	input  wire logic [3:0]         value_type,
	input  wire logic [31:0]        value_taint,
	input  wire logic               q_full,
	output logic                    q_push,
	output gtlc_pkg::q_item_t       q_item
);
	import gtlc_pkg::*;

	logic types_ok;
	logic in_win;
	logic above_min;
	logic elig;
	logic vtype_ok;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	assign types_ok  = (table_type == TYPE_TABLE) && (key_type == TYPE_STRING);
	assign above_min = (table_addr >= ADDR_MIN) && (key_addr >= ADDR_MIN);
	assign in_win    = above_min && (table_addr <= ADDR_MAX) && (key_addr <= ADDR_MAX);
	assign elig      = !bypass && types_ok && in_win;
	assign vtype_ok  = (value_type >= VTYPE_MIN) && (value_type <= VTYPE_MAX);

	always_comb begin
		q_item.owner  = owner_id;
		q_item.t_addr = table_addr;
		q_item.k_addr = key_addr;
		q_item.hash   = table_addr ^ (table_addr >> 16) ^ key_addr ^ (key_addr >> 14);
		q_item.vbits  = value_bits;
		q_item.vtype  = value_type;
		q_item.vtaint = value_taint;
		unique case (func)
			FN_LOOKUP: begin
				q_item.op = OP_LOOKUP;
				q_item.go = elig;
			end
			FN_FILL: begin
				q_item.op = OP_FILL;
				q_item.go = elig && vtype_ok;
			end
			FN_INVAL: begin
				q_item.op = OP_INVAL;
				q_item.go = types_ok && above_min;
			end
			FN_GC: begin
				q_item.op = OP_GC;
				q_item.go = 1'b1;
			end
			FN_CLEAR: begin
				q_item.op = OP_CLEAR;
				q_item.go = 1'b1;
			end
			default: begin
				q_item.op = OP_NONE;
				q_item.go = 1'b0;
			end
		endcase
	end
endmodule
`default_nettype wire

// ----- hw/rtl/gtlc_queue.sv -----
// Short queue of decoded requests between the front end and the back end.
`default_nettype none
module gtlc_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire gtlc_pkg::q_item_t  push_item,
	output logic                    full,
	input  wire logic               pop,
	output gtlc_pkg::q_item_t       head,
	output logic                    not_empty
);
	import gtlc_pkg::*;

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	q_item_t         slot_q [Q_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == CW'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/gtlc_back.sv -----
// Back end: executes requests against the entry store and registers the result beat.
`default_nettype none
module gtlc_back #(
	parameter int ENTRIES = gtlc_pkg::ENTRIES_DEF,
	localparam int IDX_W = $clog2(ENTRIES)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_valid,
	input  wire gtlc_pkg::q_item_t          q_item,
	output logic                            q_pop,
	output logic                            ram_we,
	output logic [IDX_W-1:0]                ram_waddr,
	output logic [gtlc_pkg::ENTRY_W-1:0]    ram_wdata,
	output logic                            ram_re,
	output logic [IDX_W-1:0]                ram_raddr,
	input  wire logic [gtlc_pkg::ENTRY_W-1:0] ram_rdata,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [1:0]                      status,
	output logic [63:0]                     hit_bits,
	output logic [3:0]                      hit_type,
	output logic [31:0]                     hit_taint
);
	import gtlc_pkg::*;

	bk_state_t        state_q;
	bk_state_t        state_d;
	logic [IDX_W-1:0] sweep_q;
	logic [31:0]      gen_q;
	logic [31:0]      last_owner_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [63:0]      hit_bits_q;
	logic [3:0]       hit_type_q;
	logic [31:0]      hit_taint_q;
	logic             cur_lookup_q;
	logic [63:0]      cur_tag_q;
	logic [IDX_W-1:0] cur_idx_q;

	logic             out_free;
	logic             take;
	logic             owner_chg;
	logic [31:0]      gen_next;
	logic [63:0]      item_tag;
	logic [IDX_W-1:0] item_idx;
	logic             sweep_last;
	entry_t           rd_entry;
	entry_t           wr_entry;
	logic             tag_match;

	logic             res_load;
	logic [1:0]       res_status;
	logic [63:0]      res_bits;
	logic [3:0]       res_type;
	logic [31:0]      res_taint;
	logic             start_sweep;
	logic             cur_load;
	logic             gen_load;
	logic             owner_load;

	assign out_free   = !out_valid_q || !out_stall;
	assign take       = (state_q == BK_IDLE) && q_valid && out_free;
	assign owner_chg  = (q_item.op == OP_LOOKUP) && (q_item.owner != last_owner_q);
	assign gen_next   = gen_q + 32'd1;
	assign item_tag   = {q_item.t_addr, q_item.k_addr};
	assign item_idx   = q_item.hash[IDX_W-1:0];
	assign sweep_last = (sweep_q == IDX_W'(ENTRIES - 1));
	assign rd_entry   = entry_t'(ram_rdata);
	assign tag_match  = (rd_entry.tag == cur_tag_q);
	assign ram_wdata  = ENTRY_W'(wr_entry);

	always_comb begin
		q_pop       = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = item_idx;
		wr_entry    = '0;
		ram_re      = 1'b0;
		ram_raddr   = item_idx;
		res_load    = 1'b0;
		res_status  = ST_SKIP;
		res_bits    = '0;
		res_type    = '0;
		res_taint   = '0;
		start_sweep = 1'b0;
		cur_load    = 1'b0;
		gen_load    = 1'b0;
		owner_load  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (take) begin
					q_pop = 1'b1;
					unique case (q_item.op)
						OP_LOOKUP: begin
							if (owner_chg) begin
								owner_load  = 1'b1;
								start_sweep = 1'b1;
								res_load    = 1'b1;
								res_status  = q_item.go ? ST_MISS : ST_SKIP;
							end else if (q_item.go) begin
								ram_re   = 1'b1;
								cur_load = 1'b1;
							end else begin
								res_load = 1'b1;
							end
						end
						OP_FILL: begin
							res_load = 1'b1;
							if (q_item.go) begin
								ram_we         = 1'b1;
								wr_entry.tag   = item_tag;
								wr_entry.value = q_item.vbits;
								wr_entry.vtype = q_item.vtype;
								wr_entry.taint = q_item.vtaint;
								wr_entry.stamp = gen_q;
								res_status     = ST_DONE;
							end
						end
						OP_INVAL: begin
							if (q_item.go) begin
								ram_re   = 1'b1;
								cur_load = 1'b1;
							end else begin
								res_load = 1'b1;
							end
						end
						OP_GC: begin
							gen_load    = 1'b1;
							res_load    = 1'b1;
							res_status  = ST_DONE;
							start_sweep = (gen_next == '0);
						end
						OP_CLEAR: begin
							start_sweep = 1'b1;
							res_load    = 1'b1;
							res_status  = ST_DONE;
						end
						OP_NONE: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			BK_READ: begin
				if (out_free) begin
					res_load = 1'b1;
					if (cur_lookup_q) begin
						if (tag_match && (rd_entry.stamp == gen_q)) begin
							res_status = ST_HIT;
							res_bits   = rd_entry.value;
							res_type   = rd_entry.vtype;
							res_taint  = rd_entry.taint;
						end else begin
							res_status = ST_MISS;
						end
					end else begin
						res_status = ST_DONE;
						if (tag_match) begin
							ram_we       = 1'b1;
							ram_waddr    = cur_idx_q;
							wr_entry     = rd_entry;
							wr_entry.tag = '0;
						end
					end
				end
			end
			BK_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (start_sweep) begin
					state_d = BK_SWEEP;
				end else if (ram_re) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			BK_SWEEP: begin
				if (sweep_last) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_SWEEP;
			sweep_q      <= '0;
			gen_q        <= GEN_RESET;
			last_owner_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_sweep) begin
				sweep_q <= '0;
			end else if (state_q == BK_SWEEP) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (gen_load) begin
				gen_q <= gen_next;
			end
			if (owner_load) begin
				last_owner_q <= q_item.owner;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q    <= res_status;
			hit_bits_q  <= res_bits;
			hit_type_q  <= res_type;
			hit_taint_q <= res_taint;
		end
		if (cur_load) begin
			cur_lookup_q <= (q_item.op == OP_LOOKUP);
			cur_tag_q    <= item_tag;
			cur_idx_q    <= item_idx;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign hit_bits  = hit_bits_q;
	assign hit_type  = hit_type_q;
	assign hit_taint = hit_taint_q;
endmodule
`default_nettype wire

// ----- hw/rtl/generation_tagged_lookup_cache_core.sv -----
// Top level of the generation-tagged lookup cache.
// Direct-mapped cache of (table address, key address) lookups, ENTRIES slots
// (a power of two from 16 to 65536), indexed by a xor-shift hash of the two
// addresses and tagged with both plus a generation stamp. Requests enter a
// two-beat queue and are executed one at a time against a single store with
// one write and one registered read port: a qualified lookup or invalidate
// reads its slot, then compares (an invalidate also writes back); any other
// request needs no read. After reset, and whenever the store is wiped (a
// lookup with a new owner id, a clear, or a gc step that wraps the generation
// to zero), the back end sweeps all ENTRIES slots (4096 by default), one slot a
// cycle, during which no request is executed; up to two request beats are still taken in.
// A finished result waits in an output register; while it is stalled the
// back end takes nothing further.
`default_nettype none
module generation_tagged_lookup_cache_core #(
	parameter int ENTRIES = gtlc_pkg::ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  func,
	input  wire logic        bypass,
	input  wire logic [31:0] owner_id,
	input  wire logic [3:0]  table_type,
	input  wire logic [3:0]  key_type,
	input  wire logic [31:0] table_addr,
	input  wire logic [31:0] key_addr,
	input  wire logic [63:0] value_bits,
	input  wire logic [3:0]  value_type,
	input  wire logic [31:0] value_taint,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [63:0]      hit_bits,
	output logic [3:0]       hit_type,
	output logic [31:0]      hit_taint
);
	import gtlc_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	q_item_t              push_item;
	q_item_t              head_item;
	logic                 q_push;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_valid;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [ENTRY_W-1:0]   ram_wdata;
	logic                 ram_re;
	logic [IDX_W-1:0]     ram_raddr;
	logic [ENTRY_W-1:0]   ram_rdata;

	gtlc_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.bypass      (bypass),
		.owner_id    (owner_id),
		.table_type  (table_type),
		.key_type    (key_type),
		.table_addr  (table_addr),
		.key_addr    (key_addr),
		.value_bits  (value_bits),
		.value_type  (value_type),
		.value_taint (value_taint),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (push_item)
	);

	gtlc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.head      (head_item),
		.not_empty (q_valid)
	);

	gtlc_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (head_item),
		.q_pop     (q_pop),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.hit_bits  (hit_bits),
		.hit_type  (hit_type),
		.hit_taint (hit_taint)
	);

	gtlc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);
endmodule
`default_nettype wire

// ----- hw/rtl/gtlc_checker.sv -----
// Port-level checks of the lookup cache and their attachment to the top level.
`default_nettype none
module gtlc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  status,
	input wire logic [63:0] hit_bits,
	input wire logic [3:0]  hit_type,
	input wire logic [31:0] hit_taint
);
	import gtlc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(hit_bits)
			&& $stable(hit_type) && $stable(hit_taint))
		else $error("result beat changed while stalled");

	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_HIT) |-> (hit_bits == '0) && (hit_type == '0)
			&& (hit_taint == '0))
		else $error("payload not zero on a non-hit result");

	a_hit_type: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_HIT) |-> (hit_type >= VTYPE_MIN) && (hit_type <= VTYPE_MAX))
		else $error("hit returned a value type that is never cached");

	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result beat present straight after reset");
endmodule

bind generation_tagged_lookup_cache_core gtlc_checker u_checker (.*);
`default_nettype wire
